// File: hdl/assert_macros.svh
// Assertion macros shared by the height lookup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define HTHL_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
		else $error("hthl assertion failed");

// Check that a condition never holds outside reset.
`define HTHL_ASSERT_NEVER(lbl, ck, rstn, cond) \
	`HTHL_ASSERT(lbl, ck, rstn, !(cond))

`endif

// File: hdl/hthl_pkg.sv
// Shared constants, codes and pipeline types of the heightmap height lookup.
package hthl_pkg;

	// Map storage, split into an even and an odd address bank
	localparam int MAP_DEPTH  = 4096;
	localparam int BANK_DEPTH = (MAP_DEPTH + 1) / 2;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	// Corner index width: col + (row + 1) * stride + 1 stays below 2**13
	localparam int IDX_W = 13;

	// Q0.8 one, rounding half of 65280, and 2**24 / 255 rounded down
	localparam logic [8:0]  FRAC_ONE     = 9'd256;
	localparam logic [31:0] ROUND_HALF   = 32'd32640;
	localparam logic [16:0] DIV255_RECIP = 17'd65793;
	localparam logic [23:0] DIV255       = 24'd255;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		REG_GRID_COLUMNS = 3'd0,
		REG_GRID_ROWS    = 3'd1,
		REG_OFFSET_X     = 3'd2,
		REG_OFFSET_Z     = 3'd3,
		REG_HEIGHT_SCALE = 3'd4
	} cfg_reg_t;

	// Map write toward one bank
	typedef struct packed {
		logic               en;
		logic               odd;
		logic [BANK_AW-1:0] addr;
		logic [7:0]         data;
	} wr_req_t;

	// Bank read addresses: port 0 serves the C/D pair, port 1 the A/B pair
	typedef struct packed {
		logic [BANK_AW-1:0] even0;
		logic [BANK_AW-1:0] even1;
		logic [BANK_AW-1:0] odd0;
		logic [BANK_AW-1:0] odd1;
	} rd_addr_t;

	// Registered bank read data
	typedef struct packed {
		logic [7:0] even0;
		logic [7:0] even1;
		logic [7:0] odd0;
		logic [7:0] odd1;
	} corner_t;

	// Query bookkeeping that travels with the data
	typedef struct packed {
		logic       valid;
		logic       oor;
		logic       ic_odd;
		logic       ia_odd;
		logic [7:0] s;
		logic [7:0] t;
	} meta_t;

endpackage

// File: hdl/hthl_bank_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
module hthl_bank_ram #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [DW-1:0] rdata0,
	output logic [DW-1:0] rdata1
);

	logic [DW-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read two entries
	always_ff @(posedge clk) begin
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// File: hdl/hthl_front.sv
// Request capture, bounds check and corner address generation.
module hthl_front import hthl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic        command,
	input  logic [11:0] map_index,
	input  logic [7:0]  map_value,
	input  logic [23:0] pos_x,
	input  logic [23:0] pos_z,
	input  logic [5:0]  grid_columns,
	input  logic [5:0]  grid_rows,
	input  logic [23:0] offset_x,
	input  logic [23:0] offset_z,
	output wr_req_t     wr,
	output rd_addr_t    rd_addr,
	output meta_t       meta_s2
);

	logic        valid_s1;
	logic        cmd_s1;
	logic [11:0] widx_s1;
	logic [7:0]  wval_s1;
	logic [24:0] lx_s1;
	logic [24:0] lz_s1;

	logic [15:0]      col_full;
	logic [15:0]      row_full;
	logic [6:0]       stride;
	logic [IDX_W-1:0] ic;
	logic [IDX_W-1:0] ia;
	logic [IDX_W-1:0] ic_next;
	logic [IDX_W-1:0] ia_next;
	logic             oor;
	meta_t            meta_d;

	// Hold request valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	// Capture the request and move the position into grid space
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1  <= command;
			widx_s1 <= map_index;
			wval_s1 <= map_value;
			lx_s1   <= {pos_x[23], pos_x} + {offset_x[23], offset_x};
			lz_s1   <= {pos_z[23], pos_z} + {offset_z[23], offset_z};
		end
	end

	// Locate the cell, its corners and check the bounds
	always_comb begin
		col_full = lx_s1[23:8];
		row_full = lz_s1[23:8];
		stride   = {1'b0, grid_columns} + 7'd1;
		ic       = IDX_W'(lx_s1[13:8]) + IDX_W'(lz_s1[13:8]) * IDX_W'(stride);
		ia       = ic + IDX_W'(stride);
		ic_next  = ic + IDX_W'(1);
		ia_next  = ia + IDX_W'(1);
		oor      = lx_s1[24] || lz_s1[24]
			|| (col_full >= {10'd0, grid_columns})
			|| (row_full >= {10'd0, grid_rows})
			|| (32'(ia_next) >= 32'(MAP_DEPTH));

		meta_d.valid  = valid_s1 && (cmd_s1 == CMD_QUERY);
		meta_d.oor    = oor;
		meta_d.ic_odd = ic[0];
		meta_d.ia_odd = ia[0];
		meta_d.s      = lx_s1[7:0];
		meta_d.t      = lz_s1[7:0];
	end

	// Drive the bank reads: the odd entry of a pair sits at p/2, the even at (p+1)/2
	always_comb begin
		rd_addr.odd0  = BANK_AW'(ic >> 1);
		rd_addr.even0 = BANK_AW'(ic_next >> 1);
		rd_addr.odd1  = BANK_AW'(ia >> 1);
		rd_addr.even1 = BANK_AW'(ia_next >> 1);
	end

	// Drive the map write, drop writes beyond the map
	always_comb begin
		wr.en   = valid_s1 && (cmd_s1 == CMD_WRITE) && (32'(widx_s1) < 32'(MAP_DEPTH));
		wr.odd  = widx_s1[0];
		wr.addr = BANK_AW'(widx_s1 >> 1);
		wr.data = wval_s1;
	end

	// Advance query bookkeeping alongside the bank read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
		end else begin
			meta_s2 <= meta_d;
		end
	end

endmodule

// File: hdl/hthl_interp.sv
// Triangle interpolation of the four corners and scaling by height_scale.
module hthl_interp import hthl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  meta_t       meta_s2,
	input  corner_t     rd,
	input  logic [15:0] height_scale,
	output logic        valid_s4,
	output logic        oor_s4,
	output logic [31:0] hv_s4
);

	logic [7:0]        c, d, a, b;
	logic [7:0]        base, n1, n2;
	logic [8:0]        f1, f2;
	logic              upper;
	logic signed [8:0] diff1, diff2;
	logic signed [18:0] p1, p2;

	logic               valid_s3;
	logic               oor_s3;
	logic [7:0]         base_s3;
	logic signed [18:0] p1_s3, p2_s3;

	logic signed [18:0] vsum;
	logic [15:0]        v16;

	// Sort bank data into corners and pick the triangle
	always_comb begin
		c = meta_s2.ic_odd ? rd.odd0  : rd.even0;
		d = meta_s2.ic_odd ? rd.even0 : rd.odd0;
		a = meta_s2.ia_odd ? rd.odd1  : rd.even1;
		b = meta_s2.ia_odd ? rd.even1 : rd.odd1;
		upper = ({1'b0, meta_s2.s} + {1'b0, meta_s2.t}) > FRAC_ONE;
		if (upper) begin
			base = b;
			n1   = a;
			n2   = d;
			f1   = FRAC_ONE - {1'b0, meta_s2.s};
			f2   = FRAC_ONE - {1'b0, meta_s2.t};
		end else begin
			base = c;
			n1   = d;
			n2   = a;
			f1   = {1'b0, meta_s2.s};
			f2   = {1'b0, meta_s2.t};
		end
		diff1 = $signed({1'b0, n1}) - $signed({1'b0, base});
		diff2 = $signed({1'b0, n2}) - $signed({1'b0, base});
		p1    = $signed({1'b0, f1}) * diff1;
		p2    = $signed({1'b0, f2}) * diff2;
	end

	// Hold the weighted differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= meta_s2.valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		oor_s3  <= meta_s2.oor;
		base_s3 <= base;
		p1_s3   <= p1;
		p2_s3   <= p2;
	end

	// Sum the interpolant, then scale it
	always_comb begin
		vsum = $signed({3'b000, base_s3, 8'h00}) + p1_s3 + p2_s3;
		v16  = vsum[18] ? 16'd0 : vsum[15:0];
	end

	always_ff @(posedge clk) begin
		oor_s4 <= oor_s3;
		hv_s4  <= 32'(height_scale) * 32'(v16);
	end

endmodule

// File: hdl/hthl_round.sv
// Rounded division by 65280 and the result register.
module hthl_round import hthl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s4,
	input  logic        oor_s4,
	input  logic [31:0] hv_s4,
	output logic        done,
	output logic [15:0] height,
	output logic        out_of_range
);

	logic [31:0] num;
	logic [23:0] m;
	logic [40:0] prod;

	logic        valid_s5;
	logic        oor_s5;
	logic [23:0] m_s5;
	logic [15:0] q0_s5;

	logic [23:0] back;
	logic [23:0] rem;
	logic [15:0] quo;

	logic        done_q;
	logic [15:0] height_q;
	logic        oor_q;

	// Add half, drop the factor 256, estimate the quotient by 255
	always_comb begin
		num  = hv_s4 + ROUND_HALF;
		m    = num[31:8];
		prod = 41'(m) * 41'(DIV255_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
			done_q   <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		oor_s5 <= oor_s4;
		m_s5   <= m;
		q0_s5  <= prod[39:24];
	end

	// Correct the estimate, which is low by at most one
	always_comb begin
		back = {q0_s5, 8'h00} - {8'h00, q0_s5};
		rem  = m_s5 - back;
		quo  = (rem >= DIV255) ? q0_s5 + 16'd1 : q0_s5;
	end

	// Register the result
	always_ff @(posedge clk) begin
		height_q <= oor_s5 ? 16'd0 : quo;
		oor_q    <= oor_s5;
	end

	assign done         = done_q;
	assign height       = height_q;
	assign out_of_range = oor_q;

endmodule

// File: hdl/heightmap_triangle_height_lookup.sv
// Heightmap triangle height lookup: byte map writes and interpolated height queries.
// Takes one request every cycle; busy stays low, including right after reset.
// A query's result strobes on done once it has passed the pipeline; a write gives none.
// The pipeline stages, in order: capture, bank read, weighting, scale multiply, quotient estimate, output.
// A write is visible to any query accepted on the next cycle or later.
// Reset clears the configuration to its defaults and the pipeline; the map is undefined.
`include "assert_macros.svh"

module heightmap_triangle_height_lookup import hthl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [11:0] map_index,
	input  logic [7:0]  map_value,
	input  logic [23:0] pos_x,
	input  logic [23:0] pos_z,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output logic        done,
	output logic [15:0] height,
	output logic        out_of_range
);

	logic [5:0]  cols_q;
	logic [5:0]  rows_q;
	logic [23:0] offx_q;
	logic [23:0] offz_q;
	logic [15:0] hscale_q;

	logic     take;
	wr_req_t  wr;
	rd_addr_t rd_addr;
	corner_t  rd;
	meta_t    meta_s2;
	logic     valid_s4;
	logic     oor_s4;
	logic [31:0] hv_s4;

	// Every cycle can take a request
	assign busy = 1'b0;
	assign take = start && !busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= 6'd63;
			rows_q   <= 6'd63;
			offx_q   <= 24'd0;
			offz_q   <= 24'd0;
			hscale_q <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_COLUMNS: cols_q   <= cfg_data[5:0];
				REG_GRID_ROWS:    rows_q   <= cfg_data[5:0];
				REG_OFFSET_X:     offx_q   <= cfg_data;
				REG_OFFSET_Z:     offz_q   <= cfg_data;
				REG_HEIGHT_SCALE: hscale_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	hthl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.command      (command),
		.map_index    (map_index),
		.map_value    (map_value),
		.pos_x        (pos_x),
		.pos_z        (pos_z),
		.grid_columns (cols_q),
		.grid_rows    (rows_q),
		.offset_x     (offx_q),
		.offset_z     (offz_q),
		.wr           (wr),
		.rd_addr      (rd_addr),
		.meta_s2      (meta_s2)
	);

	// Even address bank
	hthl_bank_ram #(
		.DEPTH (BANK_DEPTH),
		.AW    (BANK_AW),
		.DW    (8)
	) u_even_bank (
		.clk    (clk),
		.we     (wr.en && !wr.odd),
		.waddr  (wr.addr),
		.wdata  (wr.data),
		.raddr0 (rd_addr.even0),
		.raddr1 (rd_addr.even1),
		.rdata0 (rd.even0),
		.rdata1 (rd.even1)
	);

	// Odd address bank
	hthl_bank_ram #(
		.DEPTH (BANK_DEPTH),
		.AW    (BANK_AW),
		.DW    (8)
	) u_odd_bank (
		.clk    (clk),
		.we     (wr.en && wr.odd),
		.waddr  (wr.addr),
		.wdata  (wr.data),
		.raddr0 (rd_addr.odd0),
		.raddr1 (rd_addr.odd1),
		.rdata0 (rd.odd0),
		.rdata1 (rd.odd1)
	);

	hthl_interp u_interp (
		.clk          (clk),
		.arst_n       (arst_n),
		.meta_s2      (meta_s2),
		.rd           (rd),
		.height_scale (hscale_q),
		.valid_s4     (valid_s4),
		.oor_s4       (oor_s4),
		.hv_s4        (hv_s4)
	);

	hthl_round u_round (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s4     (valid_s4),
		.oor_s4       (oor_s4),
		.hv_s4        (hv_s4),
		.done         (done),
		.height       (height),
		.out_of_range (out_of_range)
	);

	`HTHL_ASSERT(a_query_latency, clk, arst_n, (take && command == CMD_QUERY) |-> ##6 done)
	`HTHL_ASSERT(a_write_silent, clk, arst_n, (take && command == CMD_WRITE) |-> ##6 !done)
	`HTHL_ASSERT_NEVER(a_oor_zero, clk, arst_n, done && out_of_range && height != 16'd0)
	`HTHL_ASSERT_NEVER(a_height_bound, clk, arst_n, done && !out_of_range && height > hscale_q)

endmodule

// File: test/tb_heightmap_triangle_height_lookup.sv
// Self-checking testbench for the heightmap triangle height lookup block.
module tb_heightmap_triangle_height_lookup import hthl_pkg::*;;

	localparam int DRAIN_CYCLES = 8;
	localparam int LIMIT_CYCLES = 600000;
	localparam int REPORT_LIMIT = 10;
	localparam int DIR_ROWS = 25;
	localparam int NUM_PHASES = 9;
	localparam int RANDOM_PHASE = 8;
	localparam int Q_ONE = 256;
	localparam longint ROUND_BIAS = 32640;
	localparam longint FULL_SCALE = 65280;
	localparam int REG_SLOTS = 8;

	typedef struct packed {
		logic [15:0] height;
		logic        oor;
	} height_res_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [11:0] idx;
		logic [7:0]  val;
		logic [23:0] px;
		logic [23:0] pz;
		logic        typed;
		logic [15:0] height;
		logic        oor;
	} dir_row_t;

	typedef struct packed {
		logic [5:0]  cols;
		logic [5:0]  rows;
		logic [23:0] off_x;
		logic [23:0] off_z;
		logic [15:0] scale;
		logic [11:0] budget;
	} grid_setting_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        command;
	logic [11:0] map_index;
	logic [7:0]  map_value;
	logic [23:0] pos_x;
	logic [23:0] pos_z;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;
	logic        done;
	logic [15:0] height;
	logic        out_of_range;

	// Predictor state: configuration and map contents
	logic [5:0]  cfg_cols;
	logic [5:0]  cfg_rows;
	logic [23:0] cfg_off_x;
	logic [23:0] cfg_off_z;
	logic [15:0] cfg_scale;
	logic [7:0]  terrain_map [MAP_DEPTH];
	bit          map_loaded [MAP_DEPTH];

	height_res_t pending_heights [$];
	int          mismatches = 0;
	int          requests_sent = 0;
	int          idle_pct = 0;

	// Directed requests under the reset settings (stride 64)
	dir_row_t directed_rows [DIR_ROWS] = '{
		'{CMD_WRITE, 12'd0,    8'd255, 24'h000000, 24'h000000, 1'b0, 16'd0,   1'b0},
		'{CMD_WRITE, 12'd1,    8'd255, 24'h000000, 24'h000000, 1'b0, 16'd0,   1'b0},
		'{CMD_WRITE, 12'd64,   8'd255, 24'h000000, 24'h000000, 1'b0, 16'd0,   1'b0},
		'{CMD_WRITE, 12'd65,   8'd255, 24'h000000, 24'h000000, 1'b0, 16'd0,   1'b0},
		'{CMD_QUERY, 12'd0,    8'd0,   24'h000000, 24'h000000, 1'b1, 16'd256, 1'b0},
		'{CMD_QUERY, 12'd0,    8'd0,   24'h000080, 24'h000080, 1'b1, 16'd256, 1'b0},
		'{CMD_QUERY, 12'd0,    8'd0,   24'h0000FF, 24'h0000FF, 1'b1, 16'd256, 1'b0},
		'{CMD_WRITE, 12'd65,   8'd0,   24'h000000, 24'h000000, 1'b0, 16'd0,   1'b0},
		'{CMD_QUERY, 12'd0,    8'd0,   24'h0000FF, 24'h0000FF, 1'b0, 16'd0,   1'b0},
		'{CMD_QUERY, 12'd0,    8'd0,   24'h000080, 24'h000081, 1'b0, 16'd0,   1'b0},
		'{CMD_QUERY, 12'd0,    8'd0,   24'h0000FF, 24'h000000, 1'b0, 16'd0,   1'b0},
		'{CMD_QUERY, 12'd0,    8'd0,   24'hFFFFFF, 24'h000000, 1'b1, 16'd0,   1'b1},
		'{CMD_QUERY, 12'd0,    8'd0,   24'h000000, 24'hFFFFFF, 1'b1, 16'd0,   1'b1},
		'{CMD_QUERY, 12'd0,    8'd0,   24'h7FFFFF, 24'h000000, 1'b1, 16'd0,   1'b1},
		'{CMD_QUERY, 12'd0,    8'd0,   24'h000000, 24'h800000, 1'b1, 16'd0,   1'b1},
		'{CMD_QUERY, 12'd0,    8'd0,   24'h003F00, 24'h000000, 1'b1, 16'd0,   1'b1},
		'{CMD_QUERY, 12'd0,    8'd0,   24'h000000, 24'h003F00, 1'b1, 16'd0,   1'b1},
		'{CMD_WRITE, 12'd4030, 8'd128, 24'h000000, 24'h000000, 1'b0, 16'd0,   1'b0},
		'{CMD_WRITE, 12'd4031, 8'd1,   24'h000000, 24'h000000, 1'b0, 16'd0,   1'b0},
		'{CMD_WRITE, 12'd4094, 8'd0,   24'h000000, 24'h000000, 1'b0, 16'd0,   1'b0},
		'{CMD_WRITE, 12'd4095, 8'd255, 24'h000000, 24'h000000, 1'b0, 16'd0,   1'b0},
		'{CMD_QUERY, 12'd0,    8'd0,   24'h003EFF, 24'h003EFF, 1'b0, 16'd0,   1'b0},
		'{CMD_QUERY, 12'd0,    8'd0,   24'h003E00, 24'h003E00, 1'b0, 16'd0,   1'b0},
		'{CMD_QUERY, 12'd0,    8'd0,   24'h800000, 24'h7FFFFF, 1'b1, 16'd0,   1'b1},
		'{CMD_QUERY, 12'd0,    8'd0,   24'h7FFFFF, 24'h7FFFFF, 1'b1, 16'd0,   1'b1}
	};

	// Grid settings per random phase; the last one is drawn at run time
	grid_setting_t grid_settings [NUM_PHASES] = '{
		'{6'd63, 6'd63, 24'h000000, 24'h000000, 16'd256,   12'd220},
		'{6'd1,  6'd1,  24'h000123, 24'hFFFF80, 16'd65535, 12'd220},
		'{6'd63, 6'd63, 24'h7FFFFF, 24'h800000, 16'd300,   12'd50},
		'{6'd0,  6'd5,  24'h000000, 24'h000000, 16'd256,   12'd50},
		'{6'd17, 6'd40, 24'hFFEC78, 24'h012FD1, 16'd0,     12'd220},
		'{6'd40, 6'd17, 24'h0003E8, 24'hFFFC18, 16'd1,     12'd220},
		'{6'd63, 6'd1,  24'h000100, 24'hFFFF00, 16'd12345, 12'd220},
		'{6'd1,  6'd63, 24'hFFF000, 24'h000FFF, 16'd65535, 12'd220},
		'{6'd63, 6'd63, 24'h000000, 24'h000000, 16'd256,   12'd220}
	};

	heightmap_triangle_height_lookup DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.map_index    (map_index),
		.map_value    (map_value),
		.pos_x        (pos_x),
		.pos_z        (pos_z),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.height       (height),
		.out_of_range (out_of_range)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Find the cell of a position; return 0 when it lies outside the grid
	function automatic bit locate_cell(input logic [23:0] px, input logic [23:0] pz,
			output int ic, output int ia, output int s, output int t);
		logic [24:0] lx;
		logic [24:0] lz;
		int col;
		int row;
		int stride;
		lx = {px[23], px} + {cfg_off_x[23], cfg_off_x};
		lz = {pz[23], pz} + {cfg_off_z[23], cfg_off_z};
		s = int'(lx[7:0]);
		t = int'(lz[7:0]);
		ic = 0;
		ia = 0;
		if (lx[24] || lz[24])
			return 1'b0;
		col = int'(lx[24:8]);
		row = int'(lz[24:8]);
		if (col >= cfg_cols || row >= cfg_rows)
			return 1'b0;
		stride = cfg_cols + 1;
		ic = col + row * stride;
		ia = col + (row + 1) * stride;
		return (ia + 1 < MAP_DEPTH);
	endfunction

	// Interpolate over the selected triangle and scale to Q8.8
	function automatic height_res_t predict_height(input logic [23:0] px, input logic [23:0] pz);
		height_res_t res;
		int ic, ia, s, t, c, d, a, b, v;
		longint h;
		res.height = '0;
		res.oor = 1'b1;
		if (!locate_cell(px, pz, ic, ia, s, t))
			return res;
		c = int'(terrain_map[12'(ic)]);
		d = int'(terrain_map[12'(ic + 1)]);
		a = int'(terrain_map[12'(ia)]);
		b = int'(terrain_map[12'(ia + 1)]);
		if (s + t > Q_ONE)
			v = Q_ONE * b + (Q_ONE - s) * (a - b) + (Q_ONE - t) * (d - b);
		else
			v = Q_ONE * c + s * (d - c) + t * (a - c);
		if (v < 0)
			v = 0;
		h = (longint'(cfg_scale) * v + ROUND_BIAS) / FULL_SCALE;
		res.height = (h > 65535) ? 16'hFFFF : h[15:0];
		res.oor = 1'b0;
		return res;
	endfunction

	// Present one request, wait for its acceptance, then update the predictor
	task automatic send_request(input cmd_t cmd, input logic [11:0] idx, input logic [7:0] val,
			input logic [23:0] px, input logic [23:0] pz, input bit typed,
			input height_res_t typed_res);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		map_index <= idx;
		map_value <= val;
		pos_x <= px;
		pos_z <= pz;
		do @(posedge clk); while (busy);
		if (cmd == CMD_WRITE) begin
			terrain_map[idx] = val;
			map_loaded[idx] = 1'b1;
		end else begin
			pending_heights.insert(pending_heights.size(),
				typed ? typed_res : predict_height(px, pz));
		end
		requests_sent++;
	endtask

	// Hold the sender until every pending height has come back
	task automatic hold_until_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_heights.size() != 0);
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [23:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_GRID_COLUMNS: cfg_cols = data[5:0];
			REG_GRID_ROWS:    cfg_rows = data[5:0];
			REG_OFFSET_X:     cfg_off_x = data;
			REG_OFFSET_Z:     cfg_off_z = data;
			REG_HEIGHT_SCALE: cfg_scale = data[15:0];
			default: ;
		endcase
	endtask

	// Load one grid setting, with junk in the unused upper bits
	task automatic apply_setting(input grid_setting_t g);
		logic [23:0] data;
		data = 24'($urandom);
		data[5:0] = g.cols;
		write_register(REG_GRID_COLUMNS, data);
		data = 24'($urandom);
		data[5:0] = g.rows;
		write_register(REG_GRID_ROWS, data);
		write_register(REG_OFFSET_X, g.off_x);
		write_register(REG_OFFSET_Z, g.off_z);
		data = 24'($urandom);
		data[15:0] = g.scale;
		write_register(REG_HEIGHT_SCALE, data);
		// Unassigned register slots must leave everything untouched
		for (int k = int'(REG_HEIGHT_SCALE) + 1; k < REG_SLOTS; k++)
			write_register(3'(k), 24'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Pick a coordinate along one axis: mostly inside the grid, some near or far off it
	function automatic logic [23:0] pick_coord(input int cells, input logic [23:0] off);
		int span;
		int local_pos;
		int p;
		int kind;
		kind = $urandom_range(99);
		span = (cells == 0) ? 2 * Q_ONE : cells * Q_ONE;
		if (kind < 80)
			local_pos = $urandom_range(0, span - 1);
		else if (kind < 92)
			local_pos = int'($urandom_range(0, span + 600)) - 300;
		else
			return 24'($urandom);
		p = local_pos - int'($signed(off));
		if (p < -8388608 || p > 8388607)
			return 24'($urandom);
		return p[23:0];
	endfunction

	// Query a random position, loading any corner that was never written first
	task automatic sample_terrain();
		logic [23:0] px;
		logic [23:0] pz;
		int ic, ia, s, t;
		int corners [4];
		px = pick_coord(cfg_cols, cfg_off_x);
		pz = pick_coord(cfg_rows, cfg_off_z);
		if (locate_cell(px, pz, ic, ia, s, t)) begin
			corners = '{ic, ic + 1, ia, ia + 1};
			foreach (corners[k])
				if (!map_loaded[12'(corners[k])])
					send_request(CMD_WRITE, 12'(corners[k]), 8'($urandom), 24'($urandom),
						24'($urandom), 1'b0, '0);
		end
		send_request(CMD_QUERY, 12'($urandom), 8'($urandom), px, pz, 1'b0, '0);
	endtask

	// Compare each strobed result with the oldest pending height
	always @(posedge clk) begin : check_heights
		height_res_t want;
		if (arst_n && done) begin
			if (pending_heights.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("%0t: height result %h oor %b with no query pending",
						$time, height, out_of_range);
				mismatches++;
			end else begin
				want = pending_heights.pop_front();
				if (height !== want.height || out_of_range !== want.oor) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: height exp %h got %h, oor exp %b got %b",
							$time, want.height, height, want.oor, out_of_range);
					mismatches++;
				end
			end
		end
	end

	// Stop a hung run
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("heightmap_triangle_height_lookup: mismatch");
		$finish;
	end

	initial begin
		grid_setting_t g;
		int first_req;
		arst_n <= 1'b0;
		start <= 1'b0;
		command <= CMD_WRITE;
		map_index <= '0;
		map_value <= '0;
		pos_x <= '0;
		pos_z <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cfg_cols = 6'd63;
		cfg_rows = 6'd63;
		cfg_off_x = '0;
		cfg_off_z = '0;
		cfg_scale = 16'd256;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests under the reset settings
		idle_pct = 26;
		foreach (directed_rows[i])
			send_request(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].val,
				directed_rows[i].px, directed_rows[i].pz, directed_rows[i].typed,
				'{directed_rows[i].height, directed_rows[i].oor});

		// Random phases, each under its own grid setting; sender idling depends on the phase group
		for (int p = 0; p < NUM_PHASES; p++) begin
			hold_until_drained();
			repeat (DRAIN_CYCLES) @(posedge clk);
			idle_pct = (p < 3) ? 26 : (p < 6) ? 64 : 0;
			g = grid_settings[p];
			if (p == RANDOM_PHASE) begin
				g.cols = 6'($urandom_range(1, 63));
				g.rows = 6'($urandom_range(1, 63));
				g.off_x = 24'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
				g.off_z = 24'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
				g.scale = 16'($urandom);
			end
			apply_setting(g);
			first_req = requests_sent;
			while (requests_sent - first_req < int'(g.budget)) begin
				if ($urandom_range(199) == 0)
					hold_until_drained();
				if ($urandom_range(99) < 25)
					send_request(CMD_WRITE, 12'($urandom), 8'($urandom), 24'($urandom),
						24'($urandom), 1'b0, '0);
				else
					sample_terrain();
			end
		end

		// Drain the pipeline and deliver the verdict
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_heights.size() == 0) begin
			$display("heightmap_triangle_height_lookup: match");
		end else begin
			$display("heightmap_triangle_height_lookup: mismatch");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/hthl_pkg.sv
hdl/hthl_bank_ram.sv
hdl/hthl_front.sv
hdl/hthl_interp.sv
hdl/hthl_round.sv
hdl/heightmap_triangle_height_lookup.sv
test/tb_heightmap_triangle_height_lookup.sv
